@@ hw/rtl/dyc_pkg.sv @@
// Shared types, constants and calendar tables for the day-of-year converter.
package dyc_pkg;

  localparam int YEAR_BITS = 16;
  localparam int YEAR_W    = 16;
  localparam int NYW       = (YEAR_BITS < YEAR_W) ? YEAR_BITS : YEAR_W;

  localparam logic KIND_DATE = 1'b0;
  localparam logic KIND_ORD  = 1'b1;

  localparam logic [3:0] MONTH_FIRST = 4'd1;
  localparam logic [3:0] MONTH_LAST  = 4'd12;
  localparam logic [8:0] DAYS_YEAR   = 9'd365;
  localparam logic [8:0] DAYS_LEAP   = 9'd366;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_YEAR  = 3'd1,
    ST_BAD_MONTH = 3'd2,
    ST_BAD_DAY   = 3'd3,
    ST_BAD_ORD   = 3'd4
  } status_t;

  // Multiplicative inverse of an odd constant modulo 2^32.
  function automatic logic [31:0] inv_odd(input logic [31:0] d);
    logic [31:0] x;
    x = d;
    for (int k = 0; k < 5; k++) begin
      x = x * (32'd2 - d * x);
    end
    return x;
  endfunction

  // y is a multiple of 25 exactly when y * INV25 (mod 2^NYW) <= LIM25.
  localparam logic [NYW-1:0] INV25 = NYW'(inv_odd(32'd25));
  localparam logic [NYW-1:0] LIM25 = NYW'((2**NYW - 1) / 25);

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
    logic [4:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = lp ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // Days in the months before month m.
  function automatic logic [8:0] cum_before(input logic [3:0] m, input logic lp);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    if (lp && m > 4'd2) begin
      n = n + 9'd1;
    end
    return n;
  endfunction

  typedef struct packed {
    logic           valid;
    logic           kind;
    logic           year_zero;
    logic           div4;
    logic           div16;
    logic [NYW-1:0] prod;
    logic [3:0]     month_in;
    logic [4:0]     day_in;
    logic [8:0]     ordinal_in;
  } stage_a_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic       leap;
    status_t    status;
    logic [3:0] month_sel;
    logic [4:0] day_in;
    logic [8:0] ordinal_in;
  } stage_b_t;

endpackage

@@ hw/rtl/dyc_stage_a.sv @@
// Stage A: register the request and the year divisibility terms.
module dyc_stage_a (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      kind,
  input  logic [dyc_pkg::YEAR_W-1:0] year,
  input  logic [3:0]                month_in,
  input  logic [4:0]                day_in,
  input  logic [8:0]                ordinal_in,
  output dyc_pkg::stage_a_t         a
);
  import dyc_pkg::*;

  logic [NYW-1:0] year_n;

  assign year_n = year[NYW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a.valid <= 1'b0;
    end else begin
      a.valid <= start;
    end
    a.kind       <= kind;
    a.year_zero  <= (year_n == '0);
    a.div4       <= (year_n[1:0] == 2'd0);
    a.div16      <= (year_n[3:0] == 4'd0);
    a.prod       <= NYW'(year_n * INV25);
    a.month_in   <= month_in;
    a.day_in     <= day_in;
    a.ordinal_in <= ordinal_in;
  end

endmodule

@@ hw/rtl/dyc_stage_b.sv @@
// Stage B: leap decision, range checks and month search.
module dyc_stage_b (
  input  logic              clk,
  input  logic              rst,
  input  dyc_pkg::stage_a_t a,
  output dyc_pkg::stage_b_t b
);
  import dyc_pkg::*;

  logic       div25;
  logic       lp;
  logic [8:0] top;
  logic [3:0] cnt;
  logic [3:0] month_sel;
  status_t    status;

  assign div25 = (a.prod <= LIM25);
  assign lp    = a.div4 && (!div25 || a.div16);
  assign top   = lp ? DAYS_LEAP : DAYS_YEAR;

  always_comb begin
    cnt = 4'd0;
    for (int i = 1; i < 12; i++) begin
      cnt = cnt + 4'(a.ordinal_in > cum_before(4'(i + 1), lp));
    end
  end

  always_comb begin
    status    = ST_OK;
    month_sel = a.month_in;
    if (a.year_zero) begin
      status = ST_BAD_YEAR;
    end else if (a.kind == KIND_DATE) begin
      if (a.month_in < MONTH_FIRST || a.month_in > MONTH_LAST) begin
        status = ST_BAD_MONTH;
      end else if (a.day_in == 5'd0 || a.day_in > month_len(a.month_in, lp)) begin
        status = ST_BAD_DAY;
      end
    end else begin
      month_sel = cnt + MONTH_FIRST;
      if (a.ordinal_in == 9'd0 || a.ordinal_in > top) begin
        status = ST_BAD_ORD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b.valid <= 1'b0;
    end else begin
      b.valid <= a.valid;
    end
    b.kind       <= a.kind;
    b.leap       <= lp;
    b.status     <= status;
    b.month_sel  <= month_sel;
    b.day_in     <= a.day_in;
    b.ordinal_in <= a.ordinal_in;
  end

endmodule

@@ hw/rtl/dyc_stage_c.sv @@
// Stage C: month offset add or subtract and the result register.
module dyc_stage_c (
  input  logic              clk,
  input  logic              rst,
  input  dyc_pkg::stage_b_t b,
  output logic              done,
  output logic [2:0]        status,
  output logic [8:0]        ordinal_out,
  output logic [3:0]        month_out,
  output logic [4:0]        day_out,
  output logic              leap
);
  import dyc_pkg::*;

  logic [8:0] cum;
  logic [8:0] ord_sum;
  logic [8:0] ord_rem;
  logic [8:0] ordinal_next;
  logic [3:0] month_next;
  logic [4:0] day_next;

  assign cum     = cum_before(b.month_sel, b.leap);
  assign ord_sum = cum + 9'(b.day_in);
  assign ord_rem = b.ordinal_in - cum;

  always_comb begin
    ordinal_next = 9'd0;
    month_next   = 4'd0;
    day_next     = 5'd0;
    if (b.status == ST_OK) begin
      if (b.kind == KIND_DATE) begin
        ordinal_next = ord_sum;
      end else begin
        month_next = b.month_sel;
        day_next   = ord_rem[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= b.valid;
    end
    status      <= b.status;
    leap        <= b.leap;
    ordinal_out <= ordinal_next;
    month_out   <= month_next;
    day_out     <= day_next;
  end

endmodule

@@ hw/rtl/day_of_year_converter.sv @@
// Top level of the Gregorian day-of-year converter.
//
//   channel   handshake          payload
//   request   start / busy       kind, year, month_in, day_in, ordinal_in
//   result    done (strobe)      status, ordinal_out, month_out, day_out, leap
//
// A request is taken on every cycle that start is high; busy stays low.
// Each result appears on done in order, after passing through three register
// stages: year terms, checks, output.
// Reset clears the stage valid bits; requests in flight are dropped.
// The receiver cannot stall, so nothing is ever held back.
module day_of_year_converter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       kind,
  input  logic [dyc_pkg::YEAR_W-1:0] year,
  input  logic [3:0]                 month_in,
  input  logic [4:0]                 day_in,
  input  logic [8:0]                 ordinal_in,
  output logic                       done,
  output logic [2:0]                 status,
  output logic [8:0]                 ordinal_out,
  output logic [3:0]                 month_out,
  output logic [4:0]                 day_out,
  output logic                       leap
);
  import dyc_pkg::*;

  stage_a_t a;
  stage_b_t b;
  logic     accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  dyc_stage_a u_stage_a (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .kind       (kind),
    .year       (year),
    .month_in   (month_in),
    .day_in     (day_in),
    .ordinal_in (ordinal_in),
    .a          (a)
  );

  dyc_stage_b u_stage_b (
    .clk (clk),
    .rst (rst),
    .a   (a),
    .b   (b)
  );

  dyc_stage_c u_stage_c (
    .clk         (clk),
    .rst         (rst),
    .b           (b),
    .done        (done),
    .status      (status),
    .ordinal_out (ordinal_out),
    .month_out   (month_out),
    .day_out     (day_out),
    .leap        (leap)
  );

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done) else $error("request lost in pipeline");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 3)) else $error("result without request");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (ordinal_out == 9'd0 && month_out == 4'd0
      && day_out == 5'd0)) else $error("failed request carries data");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OK) |-> ((ordinal_out != 9'd0) != (month_out != 4'd0)))
    else $error("ok result carries both or neither conversion");

  a_date_day: assert property (@(posedge clk) disable iff (rst)
    (done && month_out != 4'd0) |-> (day_out != 5'd0 && month_out <= MONTH_LAST))
    else $error("month found with bad day");
`endif

endmodule

@@ verif/dyc_conv_check_pkg.sv @@
// Request and result types, calendar predictor and scoreboard for the day-of-year converter bench.
package dyc_conv_check_pkg;
  import dyc_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [8:0]        ordinal;
  } conv_request_t;

  typedef struct packed {
    status_t    status;
    logic [8:0] ordinal;
    logic [3:0] month;
    logic [4:0] day;
    logic       leap;
  } conv_result_t;

  function automatic logic is_leap_year(input logic [YEAR_W-1:0] y);
    int unsigned v;
    v = y;
    return ((v % 4 == 0) && (v % 100 != 0)) || (v % 400 == 0);
  endfunction

  function automatic int unsigned month_days(input logic [3:0] m, input logic lp);
    int unsigned lens [13];
    lens = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m < MONTH_FIRST || m > MONTH_LAST) begin
      return 0;
    end
    return (m == 4'd2 && lp) ? 29 : lens[m];
  endfunction

  function automatic conv_result_t convert_date(input conv_request_t r);
    conv_result_t res;
    logic         lp;
    int unsigned  acc;
    int unsigned  top;
    int unsigned  m;
    lp = is_leap_year(r.year);
    res = '0;
    res.status = ST_OK;
    res.leap = lp;
    if (r.year == '0) begin
      res.status = ST_BAD_YEAR;
    end else if (r.kind == KIND_DATE) begin
      if (r.month < MONTH_FIRST || r.month > MONTH_LAST) begin
        res.status = ST_BAD_MONTH;
      end else if (r.day == '0 || r.day > month_days(r.month, lp)) begin
        res.status = ST_BAD_DAY;
      end else begin
        acc = r.day;
        for (m = 1; m < r.month; m++) begin
          acc += month_days(4'(m), lp);
        end
        res.ordinal = 9'(acc);
      end
    end else begin
      top = lp ? DAYS_LEAP : DAYS_YEAR;
      if (r.ordinal == '0 || r.ordinal > top) begin
        res.status = ST_BAD_ORD;
      end else begin
        acc = r.ordinal;
        m = 1;
        while (m < MONTH_LAST && acc > month_days(4'(m), lp)) begin
          acc -= month_days(4'(m), lp);
          m++;
        end
        res.month = 4'(m);
        res.day = 5'(acc);
      end
    end
    return res;
  endfunction

  class conv_scoreboard;
    conv_result_t expected_q [$];
    int           errors;

    function new();
      errors = 0;
    endfunction

    function void note_request(conv_request_t r);
      expected_q.push_back(convert_date(r));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(conv_result_t got);
      conv_result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected none, actual status %0d",
                 $time, got.status);
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("status", exp_r.status, got.status);
      compare_field("ordinal_out", exp_r.ordinal, got.ordinal);
      compare_field("month_out", exp_r.month, got.month);
      compare_field("day_out", exp_r.day, got.day);
      compare_field("leap", exp_r.leap, got.leap);
    endfunction
  endclass

endpackage

@@ verif/tb_day_of_year_converter.sv @@
// Self-checking bench for the day-of-year converter: directed and random requests.
module tb_day_of_year_converter;
  timeunit 1ns;
  timeprecision 1ps;

  import dyc_pkg::*;
  import dyc_conv_check_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              kind = KIND_DATE;
  logic [YEAR_W-1:0] year = '0;
  logic [3:0]        month_in = '0;
  logic [4:0]        day_in = '0;
  logic [8:0]        ordinal_in = '0;
  logic              done;
  logic [2:0]        status;
  logic [8:0]        ordinal_out;
  logic [3:0]        month_out;
  logic [4:0]        day_out;
  logic              leap;

  conv_scoreboard sb = new();

  day_of_year_converter dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .year        (year),
    .month_in    (month_in),
    .day_in      (day_in),
    .ordinal_in  (ordinal_in),
    .done        (done),
    .status      (status),
    .ordinal_out (ordinal_out),
    .month_out   (month_out),
    .day_out     (day_out),
    .leap        (leap)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(conv_result_t'({status, ordinal_out, month_out, day_out, leap}));
    end
  end

  function automatic conv_request_t make_request(input logic k, input int unsigned y,
                                                 input int unsigned m, input int unsigned d,
                                                 input int unsigned o);
    conv_request_t r;
    r.kind = k;
    r.year = YEAR_W'(y);
    r.month = 4'(m);
    r.day = 5'(d);
    r.ordinal = 9'(o);
    return r;
  endfunction

  function automatic conv_request_t random_request();
    conv_request_t r;
    logic          lp;
    r = make_request(1'($urandom_range(0, 1)), 0, $urandom, $urandom, $urandom);
    case ($urandom_range(0, 5))
      0:       r.year = YEAR_W'($urandom);
      1:       r.year = YEAR_W'(400 * $urandom_range(1, 163));
      2:       r.year = YEAR_W'(100 * $urandom_range(1, 655));
      3:       r.year = YEAR_W'(4 * $urandom_range(1, 16383));
      4:       r.year = YEAR_W'($urandom_range(1, 3000));
      default: r.year = ($urandom_range(0, 3) == 0) ? '0 : YEAR_W'($urandom_range(1, 9));
    endcase
    // well-formed most of the time, noise otherwise
    if ($urandom_range(0, 9) < 7) begin
      lp = is_leap_year(r.year);
      if (r.kind == KIND_DATE) begin
        r.month = 4'($urandom_range(1, 12));
        r.day = 5'($urandom_range(1, month_days(r.month, lp)));
      end else begin
        r.ordinal = 9'($urandom_range(1, lp ? 366 : 365));
      end
    end
    return r;
  endfunction

  task automatic send_request(input conv_request_t r, input int gap);
    @(negedge clk);
    kind <= r.kind;
    year <= r.year;
    month_in <= r.month;
    day_in <= r.day;
    ordinal_in <= r.ordinal;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_for_results();
    int guard;
    guard = 0;
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() > 0 && guard < 500) begin
      @(posedge clk);
      guard++;
    end
  endtask

  initial begin
    int  gap;
    bit  burst;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(make_request(KIND_DATE, 0, 1, 1, 0), 0);
    send_request(make_request(KIND_ORD, 0, 0, 0, 1), 3);
    send_request(make_request(KIND_DATE, 65535, 12, 31, 511), 0);
    send_request(make_request(KIND_ORD, 65535, 15, 31, 365), 1);
    send_request(make_request(KIND_DATE, 2000, 2, 29, 0), 0);
    send_request(make_request(KIND_DATE, 1900, 2, 29, 0), 2);
    send_request(make_request(KIND_DATE, 2024, 2, 29, 0), 0);
    send_request(make_request(KIND_DATE, 2023, 2, 29, 0), 0);
    send_request(make_request(KIND_DATE, 2023, 0, 10, 0), 5);
    send_request(make_request(KIND_DATE, 2023, 13, 10, 0), 0);
    send_request(make_request(KIND_DATE, 2023, 15, 31, 0), 0);
    send_request(make_request(KIND_DATE, 2023, 6, 0, 0), 14);
    send_request(make_request(KIND_DATE, 2023, 4, 31, 0), 0);
    send_request(make_request(KIND_DATE, 2024, 12, 31, 0), 0);
    send_request(make_request(KIND_DATE, 1, 1, 1, 0), 7);
    send_request(make_request(KIND_ORD, 2023, 0, 0, 0), 0);
    send_request(make_request(KIND_ORD, 2023, 0, 0, 366), 0);
    send_request(make_request(KIND_ORD, 2024, 0, 0, 366), 0);
    send_request(make_request(KIND_ORD, 2023, 0, 0, 365), 9);
    send_request(make_request(KIND_ORD, 2023, 0, 0, 1), 0);
    send_request(make_request(KIND_ORD, 2023, 0, 0, 511), 0);
    send_request(make_request(KIND_ORD, 2024, 0, 0, 60), 1);
    send_request(make_request(KIND_ORD, 2023, 0, 0, 60), 0);
    send_request(make_request(KIND_ORD, 2023, 0, 0, 59), 0);
    wait_for_results();

    burst = 1'b0;
    for (int i = 0; i < 950; i++) begin
      if (i % 60 == 0) begin
        burst = ($urandom_range(0, 2) == 0);
      end
      // hold off until the pipeline is empty
      if (i == 475) begin
        wait_for_results();
      end
      gap = burst ? 0 : $urandom_range(0, 14);
      send_request(random_request(), gap);
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: missing results, expected %0d more, actual 0", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("[day_of_year_converter] OK");
    end else begin
      $display("[day_of_year_converter] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[day_of_year_converter] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/dyc_pkg.sv
hw/rtl/dyc_stage_a.sv
hw/rtl/dyc_stage_b.sv
hw/rtl/dyc_stage_c.sv
hw/rtl/day_of_year_converter.sv
verif/dyc_conv_check_pkg.sv
verif/tb_day_of_year_converter.sv
